FILE: hw/rtl/tseo_pkg.sv
// Shared constants, codes and types of the two-state observer step.
package tseo_pkg;

  localparam int SIGNAL_WIDTH_DEF = 24;
  localparam int COEF_W           = 16;
  localparam int DT_W             = 16;
  localparam int CFG_W            = 32;
  localparam int CFG_IDX_W        = 3;
  localparam int DX_W             = 48;
  localparam int DX_HALF          = DX_W / 2;
  localparam int ACC_W            = 66;
  localparam int RND_SH           = 26;
  localparam int STEP_W           = 3;
  localparam logic [STEP_W-1:0] MAC_LAST = STEP_W'(5);

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_ROW0,
    REG_A_ROW1,
    REG_B_CONTROL,
    REG_B_COMMAND,
    REG_L_ROW0,
    REG_L_ROW1
  } cfg_reg_t;

  // Operand pair fed to the shared multiplier
  typedef enum logic [STEP_W-1:0] {
    OP_A_X0,
    OP_A_X1,
    OP_B_U,
    OP_BC_CMD,
    OP_L_D0,
    OP_L_D1,
    OP_DT_LO,
    OP_DT_HI
  } op_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SAT,
    ST_DT_LO,
    ST_DT_HI,
    ST_UPD,
    ST_DONE
  } state_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    logic    acc_en;
    logic    acc_clr;
    logic    acc_shl;
    op_sel_t sel;
    logic    elem;
    logic    dx_load;
    logic    xn_load;
    logic    finish;
  } ctrl_t;

endpackage

FILE: hw/rtl/tseo_if.sv
// Channel interfaces: input item, result item and configuration write.
interface tseo_in_if #(parameter int W = tseo_pkg::SIGNAL_WIDTH_DEF);
  import tseo_pkg::*;
  logic                valid;
  logic                ready;
  logic signed [W-1:0] u_control;
  logic signed [W-1:0] meas_0;
  logic signed [W-1:0] meas_1;
  logic signed [W-1:0] est_0;
  logic signed [W-1:0] est_1;
  logic signed [W-1:0] command;
  logic [DT_W-1:0]     step_time;

  modport source (output valid, u_control, meas_0, meas_1, est_0, est_1, command, step_time,
                  input ready);
  modport sink (input valid, u_control, meas_0, meas_1, est_0, est_1, command, step_time,
                output ready);
endinterface

interface tseo_out_if #(parameter int W = tseo_pkg::SIGNAL_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] state_0;
  logic signed [W-1:0] state_1;
  logic                step_rejected;

  modport source (output valid, state_0, state_1, step_rejected, input ready);
  modport sink (input valid, state_0, state_1, step_rejected, output ready);
endinterface

interface tseo_cfg_if;
  import tseo_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/two_state_observer_euler_step.sv
// Top level of the two-state observer forward-Euler step.
//
//   channel   dir  modport  payload
//   obs_in    in   sink     u_control meas_0 meas_1 est_0 est_1 command step_time
//   obs_out   out  source   state_0 state_1 step_rejected
//   cfg       in   sink     index data (always ready)
//
// An item with nonzero step time passes through an accept step, then through,
// per state element, six products, a clamp, two step-time products and the update,
// and a step that hands the word to the output register. An item with zero step
// time goes from the accept step to the hand-off. Reset clears the state estimate
// and arms the soft start. A stalled output holds the sequencer in its last
// step; a finished word waits in the output register while a new item is taken.
module two_state_observer_euler_step #(
  parameter int SIGNAL_WIDTH = tseo_pkg::SIGNAL_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tseo_in_if.sink    obs_in,
  tseo_out_if.source obs_out,
  tseo_cfg_if.sink   cfg
);
  import tseo_pkg::*;

  localparam int W     = SIGNAL_WIDTH;
  localparam int OPB_W = (W + 1 > DX_HALF + 1) ? W + 1 : DX_HALF + 1;
  localparam int RND_W = ACC_W - RND_SH;
  localparam int SUM_W = ((RND_W > W) ? RND_W : W) + 1;

  ctrl_t                    ctrl;
  logic                     in_ready;
  logic                     in_fire;
  logic                     zero_step;
  logic                     out_space;
  logic signed [COEF_W-1:0] cfg_coef;
  logic signed [COEF_W:0]   coef;
  logic signed [OPB_W-1:0]  opnd;
  logic signed [DX_W-1:0]   dx_sat;
  logic signed [RND_W-1:0]  rnd;

  logic signed [W-1:0]      x0;
  logic signed [W-1:0]      x1;
  logic signed [W-1:0]      xn0;
  logic signed [W-1:0]      xn1;
  logic                     pending;
  logic signed [W-1:0]      u_reg;
  logic signed [W-1:0]      cmd_reg;
  logic signed [W:0]        d0;
  logic signed [W:0]        d1;
  logic [DT_W-1:0]          dt;
  logic                     rej;
  logic signed [DX_W-1:0]   dx;

  logic signed [W-1:0]      x_cur;
  logic signed [SUM_W-1:0]  sum;
  logic signed [W-1:0]      x_sat;

  logic                     out_valid;
  logic signed [W-1:0]      out_s0;
  logic signed [W-1:0]      out_s1;
  logic                     out_rej;

  assign in_fire       = obs_in.valid && in_ready;
  assign zero_step     = (obs_in.step_time == '0);
  assign out_space     = !out_valid || obs_out.ready;
  assign obs_in.ready  = in_ready;

  tseo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .zero_step (zero_step),
    .out_space (out_space),
    .in_ready  (in_ready),
    .ctrl      (ctrl)
  );

  tseo_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .sel  (ctrl.sel),
    .elem (ctrl.elem),
    .coef (cfg_coef)
  );

  // Select the multiplier operands for the current term
  always_comb begin
    coef = (COEF_W + 1)'(cfg_coef);
    case (ctrl.sel)
      OP_A_X0:   opnd = OPB_W'(x0);
      OP_A_X1:   opnd = OPB_W'(x1);
      OP_B_U:    opnd = OPB_W'(u_reg);
      OP_BC_CMD: opnd = OPB_W'(cmd_reg);
      OP_L_D0:   opnd = OPB_W'(d0);
      OP_L_D1:   opnd = OPB_W'(d1);
      OP_DT_LO: begin
        coef = {1'b0, dt};
        opnd = OPB_W'({1'b0, dx[DX_HALF-1:0]});
      end
      OP_DT_HI: begin
        coef = {1'b0, dt};
        opnd = OPB_W'(signed'(dx[DX_W-1:DX_HALF]));
      end
      default:   opnd = '0;
    endcase
  end

  tseo_mac #(
    .OPB_W (OPB_W)
  ) u_mac (
    .clk    (clk),
    .ctrl   (ctrl),
    .coef   (coef),
    .opnd   (opnd),
    .dx_sat (dx_sat),
    .rnd    (rnd)
  );

  // Capture the item; soft start loads the state from the measurement
  always_ff @(posedge clk) begin
    if (rst) begin
      x0      <= '0;
      x1      <= '0;
      pending <= 1'b1;
    end else begin
      if (in_fire && !zero_step && pending) begin
        x0      <= obs_in.meas_0;
        x1      <= obs_in.meas_1;
        pending <= 1'b0;
      end else if (ctrl.finish && !rej) begin
        x0 <= xn0;
        x1 <= xn1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      u_reg   <= obs_in.u_control;
      cmd_reg <= obs_in.command;
      dt      <= obs_in.step_time;
      rej     <= zero_step;
      if (pending) begin
        d0 <= '0;
        d1 <= '0;
      end else begin
        d0 <= (W + 1)'(obs_in.meas_0) - (W + 1)'(obs_in.est_0);
        d1 <= (W + 1)'(obs_in.meas_1) - (W + 1)'(obs_in.est_1);
      end
    end
  end

  // Hold the clamped derivative for the step-time multiply
  always_ff @(posedge clk) begin
    if (ctrl.dx_load) begin
      dx <= dx_sat;
    end
  end

  // Add the increment to the old state and clamp to the signal range
  always_comb begin
    x_cur = ctrl.elem ? x1 : x0;
    sum   = SUM_W'(x_cur) + SUM_W'(rnd);
    if ((&sum[SUM_W-1:W-1]) || !(|sum[SUM_W-1:W-1])) begin
      x_sat = sum[W-1:0];
    end else if (sum[SUM_W-1]) begin
      x_sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      x_sat = {1'b0, {(W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.xn_load) begin
      if (ctrl.elem) begin
        xn1 <= x_sat;
      end else begin
        xn0 <= x_sat;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (obs_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_rej <= rej;
      out_s0  <= rej ? '0 : xn0;
      out_s1  <= rej ? '0 : xn1;
    end
  end

  assign obs_out.valid         = out_valid;
  assign obs_out.state_0       = out_s0;
  assign obs_out.state_1       = out_s1;
  assign obs_out.step_rejected = out_rej;

endmodule

FILE: hw/rtl/tseo_cfg_regs.sv
// Coefficient register file and coefficient select for the shared multiplier.
module tseo_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  tseo_cfg_if.sink                            cfg,
  input  tseo_pkg::op_sel_t                   sel,
  input  logic                                elem,
  output logic signed [tseo_pkg::COEF_W-1:0]  coef
);
  import tseo_pkg::*;

  logic [CFG_W-1:0] a_row0;
  logic [CFG_W-1:0] a_row1;
  logic [CFG_W-1:0] b_control;
  logic [CFG_W-1:0] b_command;
  logic [CFG_W-1:0] l_row0;
  logic [CFG_W-1:0] l_row1;
  logic [CFG_W-1:0] a_row;
  logic [CFG_W-1:0] l_row;

  assign cfg.ready = 1'b1;

  // Write one register per word; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      a_row0    <= '0;
      a_row1    <= '0;
      b_control <= '0;
      b_command <= '0;
      l_row0    <= '0;
      l_row1    <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_A_ROW0:    a_row0    <= cfg.data;
        REG_A_ROW1:    a_row1    <= cfg.data;
        REG_B_CONTROL: b_control <= cfg.data;
        REG_B_COMMAND: b_command <= cfg.data;
        REG_L_ROW0:    l_row0    <= cfg.data;
        REG_L_ROW1:    l_row1    <= cfg.data;
        default: ;
      endcase
    end
  end

  assign a_row = elem ? a_row1 : a_row0;
  assign l_row = elem ? l_row1 : l_row0;

  // Pick the coefficient half for the current term and state element
  always_comb begin
    case (sel)
      OP_A_X0:   coef = a_row[COEF_W-1:0];
      OP_A_X1:   coef = a_row[CFG_W-1:COEF_W];
      OP_B_U:    coef = elem ? b_control[CFG_W-1:COEF_W] : b_control[COEF_W-1:0];
      OP_BC_CMD: coef = elem ? b_command[CFG_W-1:COEF_W] : b_command[COEF_W-1:0];
      OP_L_D0:   coef = l_row[COEF_W-1:0];
      OP_L_D1:   coef = l_row[CFG_W-1:COEF_W];
      default:   coef = '0;
    endcase
  end

endmodule

FILE: hw/rtl/tseo_mac.sv
// Shared multiply-accumulate unit with derivative clamp and output rounding.
module tseo_mac #(
  parameter int OPB_W = 33
) (
  input  logic                                               clk,
  input  tseo_pkg::ctrl_t                                    ctrl,
  input  logic signed [tseo_pkg::COEF_W:0]                   coef,
  input  logic signed [OPB_W-1:0]                            opnd,
  output logic signed [tseo_pkg::DX_W-1:0]                   dx_sat,
  output logic signed [tseo_pkg::ACC_W-tseo_pkg::RND_SH-1:0] rnd
);
  import tseo_pkg::*;

  localparam int PROD_W = COEF_W + 1 + OPB_W;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [ACC_W-1:0]  biased;

  assign prod = PROD_W'(coef) * PROD_W'(opnd);

  // Scale the upper partial product of the step-time multiply and add the term to the accumulator or a cleared one
  always_comb begin
    term = ACC_W'(prod);
    if (ctrl.acc_shl) begin
      term = term <<< DX_HALF;
    end
    acc_next = (ctrl.acc_clr ? '0 : acc) + term;
  end

  // Accumulate one product per cycle while acc_en is high
  always_ff @(posedge clk) begin
    if (ctrl.acc_en) begin
      acc <= acc_next;
    end
  end

  // Clamp the derivative sum to the signed DX_W range
  always_comb begin
    if ((&acc[ACC_W-1:DX_W-1]) || !(|acc[ACC_W-1:DX_W-1])) begin
      dx_sat = acc[DX_W-1:0];
    end else if (acc[ACC_W-1]) begin
      dx_sat = {1'b1, {(DX_W-1){1'b0}}};
    end else begin
      dx_sat = {1'b0, {(DX_W-1){1'b1}}};
    end
  end

  // Round half up to Q.0, the scale of the state
  assign biased = acc + (ACC_W'(1) <<< (RND_SH - 1));
  assign rnd    = biased[ACC_W-1:RND_SH];

endmodule

FILE: hw/rtl/tseo_ctrl.sv
// Sequencer that steps the shared multiplier through one observer update.
module tseo_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic            zero_step,
  input  logic            out_space,
  output logic            in_ready,
  output tseo_pkg::ctrl_t ctrl
);
  import tseo_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              elem;
  logic              elem_next;

  // Advance state, term counter and element
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      elem  <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      elem  <= elem_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    step_next  = step;
    elem_next  = elem;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = zero_step ? ST_DONE : ST_MAC;
          step_next  = '0;
          elem_next  = 1'b0;
        end
      end
      ST_MAC: begin
        if (step == MAC_LAST) begin
          state_next = ST_SAT;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      ST_SAT:   state_next = ST_DT_LO;
      ST_DT_LO: state_next = ST_DT_HI;
      ST_DT_HI: state_next = ST_UPD;
      ST_UPD: begin
        if (elem) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MAC;
          step_next  = '0;
          elem_next  = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_space) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    in_ready     = 1'b0;
    ctrl         = '0;
    ctrl.elem    = elem;
    ctrl.sel     = op_sel_t'(step);
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_MAC: begin
        ctrl.acc_en  = 1'b1;
        ctrl.acc_clr = (step == '0);
      end
      ST_SAT: ctrl.dx_load = 1'b1;
      ST_DT_LO: begin
        ctrl.acc_en  = 1'b1;
        ctrl.acc_clr = 1'b1;
        ctrl.sel     = OP_DT_LO;
      end
      ST_DT_HI: begin
        ctrl.acc_en  = 1'b1;
        ctrl.acc_shl = 1'b1;
        ctrl.sel     = OP_DT_HI;
      end
      ST_UPD:  ctrl.xn_load = 1'b1;
      ST_DONE: ctrl.finish  = out_space;
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/tseo_chk.sv
// Port-level assertions for the observer step, bound to the top level.
module tseo_chk #(
  parameter int W = tseo_pkg::SIGNAL_WIDTH_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [W-1:0] state_0,
  input logic signed [W-1:0] state_1,
  input logic                step_rejected
);

  // A rejected word carries a zero state
  assert property (@(posedge clk) disable iff (rst)
    out_valid && step_rejected |-> state_0 == '0 && state_1 == '0)
    else $error("rejected word with nonzero state");

  // One item at a time: no acceptance in the cycle after one
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // A new word appears only after the block was busy
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result word without work");

  // A stalled word stays valid
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped under stall");

endmodule

bind two_state_observer_euler_step tseo_chk #(.W(SIGNAL_WIDTH)) u_tseo_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (obs_in.valid),
  .in_ready      (obs_in.ready),
  .out_valid     (obs_out.valid),
  .out_ready     (obs_out.ready),
  .state_0       (obs_out.state_0),
  .state_1       (obs_out.state_1),
  .step_rejected (obs_out.step_rejected)
);

FILE: tb/sv/testbench.sv
// Self-checking testbench of the two-state observer forward-Euler step.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tseo_pkg::*;

  localparam int SW          = SIGNAL_WIDTH_DEF;
  localparam int WIDE        = 80;
  localparam int N_GAIN_REGS = 6;
  localparam int N_DIRECTED  = 14;
  localparam int PHASE_ITEMS = 528;
  localparam int HOLD_CYCLES = 400;
  localparam int END_SETTLE  = 30;

  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = CFG_IDX_W'(7);

  localparam logic signed [SW-1:0]   S_MAX    = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0]   S_MIN    = {1'b1, {(SW-1){1'b0}}};
  localparam logic [DT_W-1:0]        DT_MAX   = '1;
  localparam logic signed [WIDE-1:0] ONE_W    = 1;
  localparam logic signed [WIDE-1:0] SIG_LIM  = (ONE_W <<< (SW-1)) - ONE_W;
  localparam logic signed [WIDE-1:0] DX_LIM   = (ONE_W <<< (DX_W-1)) - ONE_W;
  localparam logic signed [WIDE-1:0] RND_HALF = ONE_W <<< (RND_SH-1);

  typedef struct packed {
    logic signed [SW-1:0] u_control;
    logic signed [SW-1:0] meas_0;
    logic signed [SW-1:0] meas_1;
    logic signed [SW-1:0] est_0;
    logic signed [SW-1:0] est_1;
    logic signed [SW-1:0] command;
    logic [DT_W-1:0]      step_time;
  } obs_item_t;

  typedef struct packed {
    logic signed [SW-1:0] state_0;
    logic signed [SW-1:0] state_1;
    logic                 step_rejected;
  } obs_result_t;

  typedef logic [CFG_W-1:0] gain_set_t [N_GAIN_REGS];

  typedef enum logic [1:0] {GAINS_KEEP, GAINS_MAX, GAINS_MIN, GAINS_UNIT} gain_load_t;

  typedef struct {
    gain_load_t  reload;
    obs_item_t   item;
    bit          typed;
    obs_result_t result;
  } stim_row_t;

  logic clk;
  logic rst;

  tseo_in_if #(.W(SW))  obs_in_ch ();
  tseo_out_if #(.W(SW)) obs_out_ch ();
  tseo_cfg_if           cfg_ch ();

  two_state_observer_euler_step #(.SIGNAL_WIDTH(SW)) dut (
    .clk     (clk),
    .rst     (rst),
    .obs_in  (obs_in_ch.sink),
    .obs_out (obs_out_ch.source),
    .cfg     (cfg_ch.sink)
  );

  // Observer state as the block should hold it
  logic signed [SW-1:0] obs_x [2] = '{'0, '0};
  bit                   soft_start_armed = 1'b1;
  logic [CFG_W-1:0]     gain_reg [N_GAIN_REGS] = '{default: '0};

  obs_result_t pending_states [$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          recv_idle_pct  = 0;
  bit          recv_hold_req  = 1'b0;

  // Directed words: typed results only where they follow at a glance
  stim_row_t directed_table [N_DIRECTED] = '{
    // zero step before soft start: rejected, soft start stays armed
    '{GAINS_KEEP, '{S_MAX, 0, 0, 0, 0, S_MIN, 0}, 1'b1, '{0, 0, 1'b1}},
    // soft start loads the measurement, zero gains keep it
    '{GAINS_KEEP, '{S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, S_MIN, 1}, 1'b1,
      '{S_MIN, S_MAX, 1'b0}},
    '{GAINS_KEEP, '{S_MIN, S_MAX, S_MIN, S_MIN, S_MAX, S_MAX, DT_MAX}, 1'b1,
      '{S_MIN, S_MAX, 1'b0}},
    // largest gains drive the state into saturation both ways
    '{GAINS_MAX, '{S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MAX, DT_MAX}, 1'b0, '0},
    '{GAINS_KEEP, '{S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MIN, DT_MAX}, 1'b0, '0},
    '{GAINS_KEEP, '{0, S_MAX, S_MIN, S_MAX, S_MIN, 0, 0}, 1'b1, '{0, 0, 1'b1}},
    '{GAINS_KEEP, '{0, 0, 0, 0, 0, 0, 1}, 1'b0, '0},
    '{GAINS_MIN, '{S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MAX, DT_MAX}, 1'b0, '0},
    '{GAINS_KEEP, '{S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MIN, 1}, 1'b0, '0},
    '{GAINS_KEEP, '{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 0}, 1'b1, '{0, 0, 1'b1}},
    // unit gains: exact half increments round up for both signs
    '{GAINS_UNIT, '{1, 0, 0, 0, 0, 0, 16'h8000}, 1'b0, '0},
    '{GAINS_KEEP, '{-1, 0, 0, 0, 0, 0, 16'h8000}, 1'b0, '0},
    '{GAINS_KEEP, '{0, 4096, -4096, 0, 0, 12288, 16'h0400}, 1'b0, '0},
    '{GAINS_KEEP, '{2048, 8384512, -8386560, 4194304, -4194304, -2048, 16'h1234},
      1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic signed [COEF_W-1:0] gain_lo(input logic [CFG_W-1:0] r);
    return $signed(r[COEF_W-1:0]);
  endfunction

  function automatic logic signed [COEF_W-1:0] gain_hi(input logic [CFG_W-1:0] r);
    return $signed(r[CFG_W-1:COEF_W]);
  endfunction

  function automatic logic signed [WIDE-1:0] gain_mul(input logic signed [COEF_W-1:0] c,
                                                      input logic signed [WIDE-1:0] s);
    logic signed [WIDE-1:0] cw;
    cw = c;
    return cw * s;
  endfunction

  function automatic logic signed [WIDE-1:0] clamp(input logic signed [WIDE-1:0] v,
                                                   input logic signed [WIDE-1:0] lim);
    if (v > lim) return lim;
    if (v < -lim - ONE_W) return -lim - ONE_W;
    return v;
  endfunction

  // Advance the observer by one word and return the state it reports
  function automatic obs_result_t advance_observer(input obs_item_t it);
    logic signed [SW-1:0]   e0, e1;
    logic signed [SW:0]     d0, d1;
    logic signed [WIDE-1:0] dx0, dx1, dtw, nx0, nx1;
    obs_result_t            r;
    r = '0;
    if (it.step_time == '0) begin
      r.step_rejected = 1'b1;
      return r;
    end
    e0 = it.est_0;
    e1 = it.est_1;
    if (soft_start_armed) begin
      obs_x[0] = it.meas_0;
      obs_x[1] = it.meas_1;
      e0 = it.meas_0;
      e1 = it.meas_1;
      soft_start_armed = 1'b0;
    end
    d0 = $signed(it.meas_0) - e0;
    d1 = $signed(it.meas_1) - e1;
    dx0 = gain_mul(gain_lo(gain_reg[REG_A_ROW0]), obs_x[0])
        + gain_mul(gain_hi(gain_reg[REG_A_ROW0]), obs_x[1])
        + gain_mul(gain_lo(gain_reg[REG_B_CONTROL]), it.u_control)
        + gain_mul(gain_lo(gain_reg[REG_B_COMMAND]), it.command)
        + gain_mul(gain_lo(gain_reg[REG_L_ROW0]), d0)
        + gain_mul(gain_hi(gain_reg[REG_L_ROW0]), d1);
    dx1 = gain_mul(gain_lo(gain_reg[REG_A_ROW1]), obs_x[0])
        + gain_mul(gain_hi(gain_reg[REG_A_ROW1]), obs_x[1])
        + gain_mul(gain_hi(gain_reg[REG_B_CONTROL]), it.u_control)
        + gain_mul(gain_hi(gain_reg[REG_B_COMMAND]), it.command)
        + gain_mul(gain_lo(gain_reg[REG_L_ROW1]), d0)
        + gain_mul(gain_hi(gain_reg[REG_L_ROW1]), d1);
    dx0 = clamp(dx0, DX_LIM);
    dx1 = clamp(dx1, DX_LIM);
    dtw = {{(WIDE-DT_W){1'b0}}, it.step_time};
    // Round half up: add half an LSB, then floor
    nx0 = clamp(obs_x[0] + ((dx0 * dtw + RND_HALF) >>> RND_SH), SIG_LIM);
    nx1 = clamp(obs_x[1] + ((dx1 * dtw + RND_HALF) >>> RND_SH), SIG_LIM);
    obs_x[0] = nx0[SW-1:0];
    obs_x[1] = nx1[SW-1:0];
    r.state_0 = obs_x[0];
    r.state_1 = obs_x[1];
    return r;
  endfunction

  function automatic logic signed [SW-1:0] random_signal();
    logic signed [SW-1:0] v;
    case ($urandom_range(7))
      0: v = S_MAX;
      1: v = S_MIN;
      2, 3, 4: begin
        v = SW'($urandom_range(32767)) - SW'(16384);
      end
      default: v = SW'($urandom);
    endcase
    return v;
  endfunction

  function automatic obs_item_t random_item();
    obs_item_t it;
    it.u_control = random_signal();
    it.meas_0    = random_signal();
    it.meas_1    = random_signal();
    it.command   = random_signal();
    // keep the estimate near the measurement most of the time
    if ($urandom_range(3) != 0) begin
      it.est_0 = it.meas_0 + SW'($urandom_range(255)) - SW'(128);
      it.est_1 = it.meas_1 + SW'($urandom_range(255)) - SW'(128);
    end else begin
      it.est_0 = random_signal();
      it.est_1 = random_signal();
    end
    case ($urandom_range(15))
      0: it.step_time = '0;
      1: it.step_time = DT_MAX;
      2: it.step_time = DT_W'($urandom_range(15, 1));
      default: it.step_time = DT_W'($urandom_range(65535, 1));
    endcase
    return it;
  endfunction

  // Narrow sets keep every gain within +-1.0 so the state wanders instead of pinning
  function automatic gain_set_t random_gains(input bit narrow);
    gain_set_t g;
    logic [COEF_W-1:0] lo, hi;
    for (int i = 0; i < N_GAIN_REGS; i++) begin
      if (narrow) begin
        lo = COEF_W'($urandom_range(2047)) - COEF_W'(1024);
        hi = COEF_W'($urandom_range(2047)) - COEF_W'(1024);
        g[i] = {hi, lo};
      end else begin
        g[i] = $urandom;
      end
    end
    return g;
  endfunction

  // Offer one config word and hold valid high for the caller to drop
  task automatic write_word(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Write all gain registers, with junk to the unused indexes around them
  task automatic load_gains(input gain_set_t g);
    write_word(IDX_SPARE_LO, $urandom);
    for (int i = 0; i < N_GAIN_REGS; i++) begin
      write_word(cfg_reg_t'(i), g[i]);
      gain_reg[i] = g[i];
    end
    write_word(IDX_SPARE_HI, $urandom);
    cfg_ch.valid <= 1'b0;
  endtask

  // Offer one word after a random gap and queue its expected state
  task automatic send_item(input obs_item_t it, input bit typed, input obs_result_t typed_res);
    int          gap;
    obs_result_t res;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      obs_in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    obs_in_ch.valid     <= 1'b1;
    obs_in_ch.u_control <= it.u_control;
    obs_in_ch.meas_0    <= it.meas_0;
    obs_in_ch.meas_1    <= it.meas_1;
    obs_in_ch.est_0     <= it.est_0;
    obs_in_ch.est_1     <= it.est_1;
    obs_in_ch.command   <= it.command;
    obs_in_ch.step_time <= it.step_time;
    @(posedge clk);
    while (!obs_in_ch.ready) @(posedge clk);
    res = advance_observer(it);
    if (typed) res = typed_res;
    pending_states.push_back(res);
  endtask

  // Drop valid and wait until every expected state has come out
  task automatic wait_all_results();
    obs_in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_states.size() != 0);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input bit narrow,
                           input bit squeeze);
    wait_all_results();
    load_gains(random_gains(narrow));
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      // stall the output long enough to back up the input
      if (squeeze && i == PHASE_ITEMS / 5) recv_hold_req = 1'b1;
      if (squeeze && i == PHASE_ITEMS / 2) wait_all_results();
      send_item(random_item(), 1'b0, '0);
    end
  endtask

  // Result side: random ready, with one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    obs_out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (recv_hold_req) begin
        hold_left = HOLD_CYCLES;
        recv_hold_req = 1'b0;
      end
      if (rst) begin
        obs_out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        obs_out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        obs_out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    obs_result_t want;
    if (!rst && obs_out_ch.valid && obs_out_ch.ready) begin
      if (pending_states.size() == 0) begin
        $display("%0t ns: result with nothing expected: expected none, got %h %h %b", $time,
                 obs_out_ch.state_0, obs_out_ch.state_1, obs_out_ch.step_rejected);
        mismatch_count++;
      end else begin
        want = pending_states.pop_front();
        if (obs_out_ch.state_0 !== want.state_0) begin
          $display("%0t ns: state_0 expected %h, got %h", $time, want.state_0,
                   obs_out_ch.state_0);
          mismatch_count++;
        end
        if (obs_out_ch.state_1 !== want.state_1) begin
          $display("%0t ns: state_1 expected %h, got %h", $time, want.state_1,
                   obs_out_ch.state_1);
          mismatch_count++;
        end
        if (obs_out_ch.step_rejected !== want.step_rejected) begin
          $display("%0t ns: step_rejected expected %b, got %b", $time, want.step_rejected,
                   obs_out_ch.step_rejected);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed words, then three random phases
  initial begin
    gain_set_t g;
    rst <= 1'b1;
    obs_in_ch.valid     <= 1'b0;
    obs_in_ch.u_control <= '0;
    obs_in_ch.meas_0    <= '0;
    obs_in_ch.meas_1    <= '0;
    obs_in_ch.est_0     <= '0;
    obs_in_ch.est_1     <= '0;
    obs_in_ch.command   <= '0;
    obs_in_ch.step_time <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_table[i]) begin
      if (directed_table[i].reload != GAINS_KEEP) begin
        case (directed_table[i].reload)
          GAINS_MAX: g = '{default: 32'h7FFF_7FFF};
          GAINS_MIN: g = '{default: 32'h8000_8000};
          default: begin
            g[REG_A_ROW0]    = 32'h0000_0000;
            g[REG_A_ROW1]    = 32'h0000_0000;
            g[REG_B_CONTROL] = 32'h0400_0400;
            g[REG_B_COMMAND] = 32'hFC00_0400;
            g[REG_L_ROW0]    = 32'h0000_0400;
            g[REG_L_ROW1]    = 32'h0400_0000;
          end
        endcase
        wait_all_results();
        load_gains(g);
      end
      send_item(directed_table[i].item, directed_table[i].typed, directed_table[i].result);
    end

    run_phase(12, 57, 1'b1, 1'b0);
    run_phase(57, 12, 1'b0, 1'b0);
    run_phase(0, 0, 1'b1, 1'b1);

    wait_all_results();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
